// ----- rtl/tcl_pkg.sv -----
package tcl_pkg;

   localparam int WINDOW_DEPTH = 8;
   localparam int MARKER_MAX   = 4;
   localparam int KEYWORD_MAX  = 8;

   // lexing runs only while at least this many bytes are buffered, or at end of input
   localparam int LOOK   = ((MARKER_MAX + 1) < WINDOW_DEPTH) ? (MARKER_MAX + 1) : WINDOW_DEPTH;
   // marker characters actually stored in a 32-bit register
   localparam int MK     = (MARKER_MAX < 4) ? MARKER_MAX : 4;
   localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
   localparam int WLEN_W = $clog2(KEYWORD_MAX + 2);
   localparam int FIDX_W = $clog2(KEYWORD_MAX);
   localparam int WIN_W  = WINDOW_DEPTH * 8;
   localparam int BUF_W  = KEYWORD_MAX * 8;

   localparam logic [4:0] KIND_TEXT     = 5'd0;
   localparam logic [4:0] KIND_END      = 5'd1;
   localparam logic [4:0] KIND_OR       = 5'd2;
   localparam logic [4:0] KIND_EQ       = 5'd3;
   localparam logic [4:0] KIND_NE       = 5'd4;
   localparam logic [4:0] KIND_GT       = 5'd5;
   localparam logic [4:0] KIND_GE       = 5'd6;
   localparam logic [4:0] KIND_LT       = 5'd7;
   localparam logic [4:0] KIND_LE       = 5'd8;
   localparam logic [4:0] KIND_DOT      = 5'd9;
   localparam logic [4:0] KIND_LBRACE   = 5'd10;
   localparam logic [4:0] KIND_RBRACE   = 5'd11;
   localparam logic [4:0] KIND_INDEX    = 5'd12;
   localparam logic [4:0] KIND_STRING   = 5'd13;
   localparam logic [4:0] KIND_IF       = 5'd14;
   localparam logic [4:0] KIND_HAS      = 5'd15;
   localparam logic [4:0] KIND_NOT      = 5'd16;
   localparam logic [4:0] KIND_TRUE     = 5'd17;
   localparam logic [4:0] KIND_FALSE    = 5'd18;
   localparam logic [4:0] KIND_CONTAINS = 5'd19;
   localparam logic [4:0] KIND_IDENT    = 5'd20;
   localparam logic [4:0] KIND_NUMBER   = 5'd21;
   localparam logic [4:0] KIND_LINE     = 5'd22;
   localparam logic [4:0] KIND_OPEN     = 5'd23;
   localparam logic [4:0] KIND_CLOSE    = 5'd24;
   localparam logic [4:0] KIND_PAYLOAD  = 5'd25;

   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
   localparam logic [1:0] ERR_MISSING    = 2'd2;

   localparam logic [2:0] CSR_SINGLE    = 3'd0;
   localparam logic [2:0] CSR_LINE      = 3'd1;
   localparam logic [2:0] CSR_LINE_LEN  = 3'd2;
   localparam logic [2:0] CSR_OPEN      = 3'd3;
   localparam logic [2:0] CSR_OPEN_LEN  = 3'd4;
   localparam logic [2:0] CSR_CLOSE     = 3'd5;
   localparam logic [2:0] CSR_CLOSE_LEN = 3'd6;

   typedef struct packed {
      logic [4:0] kind;
      logic [7:0] data;
      logic       bv;
      logic       te;
      logic [1:0] err;
   } result_type;

   typedef struct packed {
      logic push;
      logic restart;
      logic decide;
      logic act;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic ctx_und;
      logic look_ok;
      logic err;
      logic act_stop;
      logic act_flush;
      logic flush_last;
   } status_type;

   function automatic int eff_len(input logic [2:0] k);
      int kk;
      kk = int'(k);
      if (kk > MK) kk = MK;
      return kk;
   endfunction

   // marker (optionally '}' before, '?' after) at window offset off
   function automatic logic marker_hit(input logic [WIN_W-1:0] win,
                                       input logic [FILL_W-1:0] fill,
                                       input logic [31:0] chars,
                                       input logic [2:0] k,
                                       input logic brace,
                                       input logic q,
                                       input int off);
      logic       hit;
      int         kk;
      int         n;
      int         pos;
      int         idx;
      logic [7:0] p;
      kk  = eff_len(k);
      hit = (kk != 0);
      n   = kk + int'(brace) + int'(q);
      for (int j = 0; j < MK + 2; j++) begin
         if (j < n) begin
            pos = j + off;
            if (brace && j == 0) begin
               p = 8'h7d;
            end else begin
               idx = j - int'(brace);
               if (idx < kk) p = chars[idx*8 +: 8];
               else p = 8'h3f;
            end
            if (pos >= WINDOW_DEPTH || pos >= int'(fill)) hit = 1'b0;
            else if (win[pos*8 +: 8] != p) hit = 1'b0;
         end
      end
      return hit;
   endfunction

   function automatic logic [FILL_W-1:0] marker_len(input logic [2:0] k, input logic extra);
      return FILL_W'(eff_len(k) + int'(extra));
   endfunction

endpackage

// ----- rtl/tcl_out_stage.sv -----
module tcl_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tcl_pkg::result_type res,
   input  logic                finish,
   output logic                can_go,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [4:0]          rsp_token_kind,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_byte_valid,
   output logic                rsp_token_end,
   output logic [1:0]          rsp_error_code,
   output logic                rsp_last_of_run
);

   // newest result waits in hold until the next one, or the item end, tells
   // whether it is the last of its run
   tcl_pkg::result_type hold_ff, hold_in, out_ff, out_in;
   logic hv_ff, hv_in, rsp_valid_ff, rsp_valid_in, last_ff, last_in;
   logic out_free;

   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      can_go       = !hv_ff || out_free;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_in       = out_ff;
      last_in      = last_ff;
      hold_in      = hold_ff;
      hv_in        = hv_ff;
      if (push && can_go) begin
         if (hv_ff) begin
            rsp_valid_in = 1'b1;
            out_in       = hold_ff;
            last_in      = 1'b0;
         end
         hold_in = res;
         hv_in   = 1'b1;
      end else if (finish && can_go && hv_ff) begin
         rsp_valid_in = 1'b1;
         out_in       = hold_ff;
         last_in      = 1'b1;
         hv_in        = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hv_ff        <= hv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hold_ff <= hold_in;
      out_ff  <= out_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_token_kind  = out_ff.kind;
   assign rsp_out_byte    = out_ff.data;
   assign rsp_byte_valid  = out_ff.bv;
   assign rsp_token_end   = out_ff.te;
   assign rsp_error_code  = out_ff.err;
   assign rsp_last_of_run = last_ff;

endmodule

// ----- rtl/tcl_datapath.sv -----
module tcl_datapath (
   input  logic                clock,
   input  logic                reset,
   input  tcl_pkg::cmd_type    cmd,
   input  logic [7:0]          text_byte,
   output tcl_pkg::status_type status,
   output logic                emit_valid,
   output tcl_pkg::result_type emit_res,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_data
);

   typedef enum logic [1:0] {
      CTX_ARB = 2'd0,
      CTX_PAY = 2'd1,
      CTX_SEC = 2'd2,
      CTX_UND = 2'd3
   } ctx_type;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_ARB   = 3'd1,
      MODE_PAY   = 3'd2,
      MODE_IDENT = 3'd3,
      MODE_NUM   = 3'd4,
      MODE_STR   = 3'd5,
      MODE_IDX0  = 3'd6,
      MODE_IDX   = 3'd7
   } mode_type;

   logic        single_ff;
   logic [31:0] line_ff, open_ff, close_ff;
   logic [2:0]  line_len_ff, open_len_ff, close_len_ff;

   logic [tcl_pkg::WIN_W-1:0]  win_ff, win_in;
   logic [tcl_pkg::FILL_W-1:0] fill_ff, fill_in;
   ctx_type                    ctx_ff, ctx_in;
   mode_type                   mode_ff, mode_in;
   logic [tcl_pkg::BUF_W-1:0]  buf_ff, buf_in;
   logic [tcl_pkg::WLEN_W-1:0] wlen_ff, wlen_in;
   logic [tcl_pkg::FIDX_W-1:0] fidx_ff, fidx_in;
   logic                       err_ff, err_in;

   logic [7:0] c, p1;
   logic       c_ok, p1_ok, c_space, c_digit, c_alpha, c_word;
   logic       m_line, m_open, m_close, m_pay, m_brace, m_close1;
   logic [tcl_pkg::FILL_W-1:0] n_line, n_open, n_close, n_pay;
   logic [7:0] pay_next;
   logic [4:0] kw;

   // outcome of one lexing action
   logic                       a_emit, a_stop, a_flush, a_restart, a_err;
   tcl_pkg::result_type        a_res;
   logic [tcl_pkg::FILL_W-1:0] a_take;
   ctx_type                    a_ctx;
   mode_type                   a_mode;
   logic [tcl_pkg::BUF_W-1:0]  a_buf;
   logic [tcl_pkg::WLEN_W-1:0] a_wlen;

   function automatic tcl_pkg::result_type tok(input logic [4:0] kind);
      tcl_pkg::result_type r;
      r      = '0;
      r.kind = kind;
      r.te   = 1'b1;
      return r;
   endfunction

   function automatic tcl_pkg::result_type chr(input logic [7:0] b);
      tcl_pkg::result_type r;
      r      = '0;
      r.data = b;
      r.bv   = 1'b1;
      return r;
   endfunction

   function automatic tcl_pkg::result_type fail(input logic [1:0] code);
      tcl_pkg::result_type r;
      r     = '0;
      r.err = code;
      return r;
   endfunction

   function automatic logic [4:0] keyword(input logic [tcl_pkg::BUF_W-1:0] b,
                                          input logic [tcl_pkg::WLEN_W-1:0] n);
      logic [4:0] k;
      k = tcl_pkg::KIND_TEXT;
      if (n == tcl_pkg::WLEN_W'(2) && b[15:0] == "fi") k = tcl_pkg::KIND_IF;
      if (n == tcl_pkg::WLEN_W'(3) && b[23:0] == "sah") k = tcl_pkg::KIND_HAS;
      if (n == tcl_pkg::WLEN_W'(3) && b[23:0] == "ton") k = tcl_pkg::KIND_NOT;
      if (n == tcl_pkg::WLEN_W'(4) && b[31:0] == "eurt") k = tcl_pkg::KIND_TRUE;
      if (n == tcl_pkg::WLEN_W'(5) && b[39:0] == "eslaf") k = tcl_pkg::KIND_FALSE;
      if (n == tcl_pkg::WLEN_W'(8) && b[63:0] == "sniatnoc") k = tcl_pkg::KIND_CONTAINS;
      return k;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         single_ff    <= 1'b0;
         line_ff      <= '0;
         line_len_ff  <= '0;
         open_ff      <= '0;
         open_len_ff  <= '0;
         close_ff     <= '0;
         close_len_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            tcl_pkg::CSR_SINGLE:    single_ff    <= csr_data[0];
            tcl_pkg::CSR_LINE:      line_ff      <= csr_data;
            tcl_pkg::CSR_LINE_LEN:  line_len_ff  <= csr_data[2:0];
            tcl_pkg::CSR_OPEN:      open_ff      <= csr_data;
            tcl_pkg::CSR_OPEN_LEN:  open_len_ff  <= csr_data[2:0];
            tcl_pkg::CSR_CLOSE:     close_ff     <= csr_data;
            tcl_pkg::CSR_CLOSE_LEN: close_len_ff <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      c       = win_ff[7:0];
      p1      = win_ff[15:8];
      c_ok    = (fill_ff != '0);
      p1_ok   = (fill_ff > tcl_pkg::FILL_W'(1));
      c_space = c_ok && (c == 8'h20 || (c >= 8'h09 && c <= 8'h0d));
      c_digit = c_ok && c >= "0" && c <= "9";
      c_alpha = c_ok && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"));
      c_word  = c_alpha || c_digit || (c_ok && c == "_");
      m_line  = tcl_pkg::marker_hit(win_ff, fill_ff, line_ff, line_len_ff, 1'b0, 1'b1, 0);
      m_open  = tcl_pkg::marker_hit(win_ff, fill_ff, open_ff, open_len_ff, 1'b0, 1'b1, 0);
      m_close = tcl_pkg::marker_hit(win_ff, fill_ff, close_ff, close_len_ff, 1'b0, 1'b0, 0);
      m_pay   = tcl_pkg::marker_hit(win_ff, fill_ff, line_ff, line_len_ff, 1'b0, 1'b0, 0);
      m_brace = tcl_pkg::marker_hit(win_ff, fill_ff, close_ff, close_len_ff, 1'b1, 1'b0, 0);
      m_close1 = tcl_pkg::marker_hit(win_ff, fill_ff, close_ff, close_len_ff, 1'b0, 1'b0, 1);
      n_line  = tcl_pkg::marker_len(line_len_ff, 1'b1);
      n_open  = tcl_pkg::marker_len(open_len_ff, 1'b1);
      n_close = tcl_pkg::marker_len(close_len_ff, 1'b0);
      n_pay   = tcl_pkg::marker_len(line_len_ff, 1'b0);
      pay_next = 8'(win_ff >> ({3'b0, n_pay} * 8));
      kw      = keyword(buf_ff, wlen_ff);
   end

   always_comb begin
      a_emit    = 1'b0;
      a_stop    = 1'b0;
      a_flush   = 1'b0;
      a_restart = 1'b0;
      a_err     = 1'b0;
      a_res     = '0;
      a_take    = '0;
      a_ctx     = ctx_ff;
      a_mode    = mode_ff;
      a_buf     = buf_ff;
      a_wlen    = wlen_ff;
      unique case (mode_ff)
         MODE_IDLE: begin
            if (ctx_ff != CTX_ARB && c_space) begin
               a_take = tcl_pkg::FILL_W'(1);
            end else if (!c_ok) begin
               a_emit    = 1'b1;
               a_res     = tok(tcl_pkg::KIND_END);
               a_restart = 1'b1;
               a_stop    = 1'b1;
            end else if (ctx_ff == CTX_ARB) begin
               a_mode = MODE_ARB;
            end else if (ctx_ff == CTX_PAY) begin
               a_mode = MODE_PAY;
            end else if (m_line) begin
               a_emit = 1'b1; a_res = tok(tcl_pkg::KIND_LINE); a_take = n_line;
            end else if (m_open) begin
               a_emit = 1'b1; a_res = tok(tcl_pkg::KIND_OPEN); a_take = n_open;
            end else if (m_close) begin
               a_emit = 1'b1; a_res = tok(tcl_pkg::KIND_CLOSE); a_take = n_close;
               a_ctx  = CTX_ARB;
            end else if (m_pay) begin
               a_emit = 1'b1; a_res = tok(tcl_pkg::KIND_PAYLOAD); a_take = n_pay;
            end else begin
               a_emit = 1'b1;
               a_take = tcl_pkg::FILL_W'(1);
               unique case (c)
                  "|": a_res = tok(tcl_pkg::KIND_OR);
                  "=", "!": begin
                     if (p1_ok && p1 == "=") begin
                        a_res  = tok((c == "=") ? tcl_pkg::KIND_EQ : tcl_pkg::KIND_NE);
                        a_take = tcl_pkg::FILL_W'(2);
                     end else begin
                        a_res  = fail(tcl_pkg::ERR_MISSING);
                        a_take = '0;
                        a_err  = 1'b1;
                        a_stop = 1'b1;
                     end
                  end
                  ">", "<": begin
                     if (p1_ok && p1 == "=") begin
                        a_res  = tok((c == ">") ? tcl_pkg::KIND_GE : tcl_pkg::KIND_LE);
                        a_take = tcl_pkg::FILL_W'(2);
                     end else begin
                        a_res = tok((c == ">") ? tcl_pkg::KIND_GT : tcl_pkg::KIND_LT);
                     end
                  end
                  ".": a_res = tok(tcl_pkg::KIND_DOT);
                  "{": begin
                     a_res = tok(tcl_pkg::KIND_LBRACE);
                     a_ctx = CTX_PAY;
                  end
                  "}": begin
                     a_res = tok(tcl_pkg::KIND_RBRACE);
                     if (!m_close1) a_ctx = CTX_ARB;
                  end
                  "[": begin
                     a_emit = 1'b0;
                     a_mode = MODE_IDX0;
                  end
                  "\"": begin
                     a_emit = 1'b0;
                     a_mode = MODE_STR;
                  end
                  default: begin
                     if (c_alpha || c == "_") begin
                        a_emit = 1'b0;
                        a_buf  = tcl_pkg::BUF_W'(c);
                        a_wlen = tcl_pkg::WLEN_W'(1);
                        a_mode = MODE_IDENT;
                     end else if (c_digit) begin
                        a_res  = chr(c);
                        a_mode = MODE_NUM;
                     end else begin
                        a_res  = fail(tcl_pkg::ERR_UNEXPECTED);
                        a_take = '0;
                        a_err  = 1'b1;
                        a_stop = 1'b1;
                     end
                  end
               endcase
            end
         end
         MODE_ARB: begin
            a_emit = 1'b1;
            if (!c_ok || m_line || m_open) begin
               a_ctx  = CTX_SEC;
               a_mode = MODE_IDLE;
               a_res  = tok(tcl_pkg::KIND_TEXT);
            end else begin
               a_res  = chr(c);
               a_take = tcl_pkg::FILL_W'(1);
            end
         end
         MODE_PAY: begin
            if (!c_ok || m_line || m_brace) begin
               a_emit = 1'b1;
               a_ctx  = CTX_SEC;
               a_mode = MODE_IDLE;
               a_res  = tok(tcl_pkg::KIND_TEXT);
            end else if (m_pay) begin
               // escaped: the byte after the marker is taken as text
               a_take = n_pay;
               if (n_pay < fill_ff) begin
                  a_emit = 1'b1;
                  a_res  = chr(pay_next);
                  a_take = n_pay + tcl_pkg::FILL_W'(1);
               end
            end else begin
               a_emit = 1'b1;
               a_res  = chr(c);
               a_take = tcl_pkg::FILL_W'(1);
            end
         end
         MODE_IDENT: begin
            if (c_word) begin
               if (wlen_ff < tcl_pkg::WLEN_W'(tcl_pkg::KEYWORD_MAX)) begin
                  a_buf  = buf_ff | (tcl_pkg::BUF_W'(c) << ({3'b0, wlen_ff} * 8));
                  a_wlen = wlen_ff + tcl_pkg::WLEN_W'(1);
                  a_take = tcl_pkg::FILL_W'(1);
               end else if (wlen_ff == tcl_pkg::WLEN_W'(tcl_pkg::KEYWORD_MAX)) begin
                  a_flush = 1'b1;
               end else begin
                  a_emit = 1'b1;
                  a_res  = chr(c);
                  a_take = tcl_pkg::FILL_W'(1);
               end
            end else if (wlen_ff <= tcl_pkg::WLEN_W'(tcl_pkg::KEYWORD_MAX) &&
                         kw == tcl_pkg::KIND_TEXT) begin
               a_flush = 1'b1;
            end else begin
               a_emit = 1'b1;
               a_res  = tok((kw == tcl_pkg::KIND_TEXT) ? tcl_pkg::KIND_IDENT : kw);
               a_buf  = '0;
               a_wlen = '0;
               a_mode = MODE_IDLE;
            end
         end
         MODE_NUM: begin
            a_emit = 1'b1;
            if (c_digit) begin
               a_res  = chr(c);
               a_take = tcl_pkg::FILL_W'(1);
            end else begin
               a_res  = tok(tcl_pkg::KIND_NUMBER);
               a_mode = MODE_IDLE;
            end
         end
         MODE_STR: begin
            a_emit = 1'b1;
            if (!c_ok || (c == "\\" && !p1_ok)) begin
               a_res  = fail(tcl_pkg::ERR_MISSING);
               a_err  = 1'b1;
               a_stop = 1'b1;
            end else if (c == "\"") begin
               a_res  = tok(tcl_pkg::KIND_STRING);
               a_mode = MODE_IDLE;
               a_take = tcl_pkg::FILL_W'(1);
            end else if (c == "\\") begin
               a_res  = chr(p1);
               a_take = tcl_pkg::FILL_W'(2);
            end else begin
               a_res  = chr(c);
               a_take = tcl_pkg::FILL_W'(1);
            end
         end
         MODE_IDX0: begin
            a_emit = 1'b1;
            if (!c_ok) begin
               a_res  = fail(tcl_pkg::ERR_MISSING);
               a_err  = 1'b1;
               a_stop = 1'b1;
            end else begin
               a_res  = chr(c);
               a_take = tcl_pkg::FILL_W'(1);
               a_mode = MODE_IDX;
            end
         end
         MODE_IDX: begin
            a_emit = 1'b1;
            if (c_digit) begin
               a_res  = chr(c);
               a_take = tcl_pkg::FILL_W'(1);
            end else if (c_ok && c == "]") begin
               a_res  = tok(tcl_pkg::KIND_INDEX);
               a_mode = MODE_IDLE;
               a_take = tcl_pkg::FILL_W'(1);
            end else begin
               a_res  = fail(tcl_pkg::ERR_MISSING);
               a_err  = 1'b1;
               a_stop = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      win_in  = win_ff;
      fill_in = fill_ff;
      ctx_in  = ctx_ff;
      mode_in = mode_ff;
      buf_in  = buf_ff;
      wlen_in = wlen_ff;
      fidx_in = fidx_ff;
      err_in  = err_ff;
      if (cmd.restart || (cmd.act && a_restart)) begin
         fill_in = '0;
         ctx_in  = CTX_UND;
         mode_in = MODE_IDLE;
         buf_in  = '0;
         wlen_in = '0;
         fidx_in = '0;
         err_in  = 1'b0;
      end else if (cmd.push) begin
         if (fill_ff < tcl_pkg::FILL_W'(tcl_pkg::WINDOW_DEPTH)) begin
            win_in[int'(fill_ff)*8 +: 8] = text_byte;
            fill_in = fill_ff + tcl_pkg::FILL_W'(1);
         end
      end else if (cmd.decide) begin
         ctx_in = (single_ff || m_line || m_open) ? CTX_SEC : CTX_ARB;
      end else if (cmd.act && !a_flush) begin
         win_in  = win_ff >> ({3'b0, a_take} * 8);
         fill_in = fill_ff - a_take;
         ctx_in  = a_ctx;
         mode_in = a_mode;
         buf_in  = a_buf;
         wlen_in = a_wlen;
         err_in  = err_ff | a_err;
      end else if (cmd.flush) begin
         if (status.flush_last) begin
            wlen_in = tcl_pkg::WLEN_W'(tcl_pkg::KEYWORD_MAX + 1);
            fidx_in = '0;
         end else begin
            fidx_in = fidx_ff + tcl_pkg::FIDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         ctx_ff  <= CTX_UND;
         mode_ff <= MODE_IDLE;
         buf_ff  <= '0;
         wlen_ff <= '0;
         fidx_ff <= '0;
         err_ff  <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         ctx_ff  <= ctx_in;
         mode_ff <= mode_in;
         buf_ff  <= buf_in;
         wlen_ff <= wlen_in;
         fidx_ff <= fidx_in;
         err_ff  <= err_in;
      end
      win_ff <= win_in;
   end

   always_comb begin
      status.ctx_und    = (ctx_ff == CTX_UND);
      status.look_ok    = (fill_ff >= tcl_pkg::FILL_W'(tcl_pkg::LOOK));
      status.err        = err_ff;
      status.act_stop   = a_stop;
      status.act_flush  = a_flush;
      status.flush_last = (fidx_ff == tcl_pkg::FIDX_W'(wlen_ff - tcl_pkg::WLEN_W'(1)));
      emit_valid        = (cmd.act && a_emit && !a_flush) || cmd.flush;
      emit_res          = cmd.flush ? chr(buf_ff[int'(fidx_ff)*8 +: 8]) : a_res;
   end

endmodule

// ----- rtl/tcl_controller.sv -----
module tcl_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_end_of_input,
   output logic                req_stall,
   input  tcl_pkg::status_type status,
   input  logic                can_go,
   output tcl_pkg::cmd_type    cmd,
   output logic                finish
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_STEP  = 4'b0010,
      ST_FLUSH = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      eoi_ff, eoi_in;

   always_comb begin
      state_in = state_ff;
      eoi_in   = eoi_ff;
      cmd      = '0;
      finish   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (status.err) begin
                  // after an error, end of input only restarts the text
                  cmd.restart = req_end_of_input;
               end else begin
                  cmd.push = !req_end_of_input;
                  eoi_in   = req_end_of_input;
                  state_in = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            if (can_go) begin
               if (status.ctx_und) begin
                  if (eoi_ff || status.look_ok) cmd.decide = 1'b1;
                  else state_in = ST_DONE;
               end else if (!eoi_ff && (status.err || !status.look_ok)) begin
                  state_in = ST_DONE;
               end else begin
                  cmd.act = 1'b1;
                  if (status.act_flush) state_in = ST_FLUSH;
                  else if (status.act_stop) state_in = ST_DONE;
               end
            end
         end
         ST_FLUSH: begin
            if (can_go) begin
               cmd.flush = 1'b1;
               if (status.flush_last) state_in = ST_STEP;
            end
         end
         ST_DONE: begin
            if (can_go) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         eoi_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         eoi_ff   <= eoi_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// ----- rtl/template_comment_lexer_unit.sv -----
// Template comment lexer: one text byte (or an end-of-input beat) is taken
// per req beat; the resulting token bytes and token-end beats come out on rsp
// at most one per cycle while rsp is not stalled, with rsp_last_of_run on the
// final beat of each input beat. A text beat passes through accept, lexer
// actions on the 8-byte lookahead window, a final window check and finish; a
// result waits in a hold register until the next result or the finish, then
// is registered onto rsp. Choosing the context at the start of a text adds a
// decide step. An identifier that reaches keyword length or ends without a
// keyword match has its held bytes flushed one by one. An end-of-input beat
// is accepted, drains the window and finishes. Input stalls while a beat is
// in process; results wait while rsp stalls. The csr port is always ready and
// must only be written while the block is idle.
module template_comment_lexer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_token_kind,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_token_end,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_last_of_run,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   tcl_pkg::cmd_type    cmd;
   tcl_pkg::status_type status;
   tcl_pkg::result_type emit_res;
   logic                emit_valid, can_go, finish;

   assign csr_ready = 1'b1;

   tcl_controller u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_end_of_input (req_end_of_input),
      .req_stall        (req_stall),
      .status           (status),
      .can_go           (can_go),
      .cmd              (cmd),
      .finish           (finish)
   );

   tcl_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .text_byte  (req_text_byte),
      .status     (status),
      .emit_valid (emit_valid),
      .emit_res   (emit_res),
      .csr_write  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   tcl_out_stage u_out (
      .clock           (clock),
      .reset           (reset),
      .push            (emit_valid),
      .res             (emit_res),
      .finish          (finish),
      .can_go          (can_go),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_token_end   (rsp_token_end),
      .rsp_error_code  (rsp_error_code),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
